>>> rtl/lbm_eq_pkg.sv
// ----------------------------------------------------------------------------
// lbm_eq_pkg
// Shared types, direction table and divide-by-constant step for the D3Q19
// BGK equilibrium generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lbm_eq_pkg;

  localparam int unsigned NumDirs = 19;
  localparam int unsigned DirW    = 5;
  localparam logic [DirW-1:0] LastDir = DirW'(NumDirs - 1);

  // population divides by D * 2^17, D = 3 * 2^k * {1 or 3}
  typedef enum logic [1:0] {
    WeightRest,   // D = 3
    WeightAxis,   // D = 18
    WeightDiag    // D = 36
  } weight_e;

  typedef struct packed {
    logic    x_en;
    logic    x_neg;
    logic    y_en;
    logic    y_neg;
    logic    z_en;
    logic    z_neg;
    weight_e wclass;
  } dir_info_t;

  typedef struct packed {
    logic [6:0] quo;
    logic [3:0] rem;
  } div_step_t;

  function automatic dir_info_t dir_info(logic [DirW-1:0] dir);
    dir_info_t d;
    d = '{default: 1'b0, wclass: WeightRest};
    unique case (dir)
      5'd1:  d = '{x_en: 1'b1, x_neg: 1'b0, y_en: 1'b0, y_neg: 1'b0,
                   z_en: 1'b0, z_neg: 1'b0, wclass: WeightAxis};
      5'd2:  d = '{x_en: 1'b1, x_neg: 1'b1, y_en: 1'b0, y_neg: 1'b0,
                   z_en: 1'b0, z_neg: 1'b0, wclass: WeightAxis};
      5'd3:  d = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b0,
                   z_en: 1'b0, z_neg: 1'b0, wclass: WeightAxis};
      5'd4:  d = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b1,
                   z_en: 1'b0, z_neg: 1'b0, wclass: WeightAxis};
      5'd5:  d = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b0, y_neg: 1'b0,
                   z_en: 1'b1, z_neg: 1'b0, wclass: WeightAxis};
      5'd6:  d = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b0, y_neg: 1'b0,
                   z_en: 1'b1, z_neg: 1'b1, wclass: WeightAxis};
      5'd7:  d = '{x_en: 1'b1, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b0,
                   z_en: 1'b0, z_neg: 1'b0, wclass: WeightDiag};
      5'd8:  d = '{x_en: 1'b1, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b1,
                   z_en: 1'b0, z_neg: 1'b0, wclass: WeightDiag};
      5'd9:  d = '{x_en: 1'b1, x_neg: 1'b0, y_en: 1'b0, y_neg: 1'b0,
                   z_en: 1'b1, z_neg: 1'b0, wclass: WeightDiag};
      5'd10: d = '{x_en: 1'b1, x_neg: 1'b0, y_en: 1'b0, y_neg: 1'b0,
                   z_en: 1'b1, z_neg: 1'b1, wclass: WeightDiag};
      5'd11: d = '{x_en: 1'b1, x_neg: 1'b1, y_en: 1'b1, y_neg: 1'b0,
                   z_en: 1'b0, z_neg: 1'b0, wclass: WeightDiag};
      5'd12: d = '{x_en: 1'b1, x_neg: 1'b1, y_en: 1'b1, y_neg: 1'b1,
                   z_en: 1'b0, z_neg: 1'b0, wclass: WeightDiag};
      5'd13: d = '{x_en: 1'b1, x_neg: 1'b1, y_en: 1'b0, y_neg: 1'b0,
                   z_en: 1'b1, z_neg: 1'b0, wclass: WeightDiag};
      5'd14: d = '{x_en: 1'b1, x_neg: 1'b1, y_en: 1'b0, y_neg: 1'b0,
                   z_en: 1'b1, z_neg: 1'b1, wclass: WeightDiag};
      5'd15: d = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b0,
                   z_en: 1'b1, z_neg: 1'b0, wclass: WeightDiag};
      5'd16: d = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b0,
                   z_en: 1'b1, z_neg: 1'b1, wclass: WeightDiag};
      5'd17: d = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b1,
                   z_en: 1'b1, z_neg: 1'b0, wclass: WeightDiag};
      5'd18: d = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b1,
                   z_en: 1'b1, z_neg: 1'b1, wclass: WeightDiag};
      default: d = '{default: 1'b0, wclass: WeightRest};
    endcase
    return d;
  endfunction

  // one velocity term of c.v, lattice component in {-1, 0, +1}
  function automatic logic signed [17:0] vel_term(logic en, logic neg,
                                                  logic signed [15:0] v);
    logic signed [17:0] ext;
    ext = 18'(v);
    if (!en) begin
      return '0;
    end else if (neg) begin
      return -ext;
    end else begin
      return ext;
    end
  endfunction

  // one long-division digit step by 3 or 9, radix 128; v < 9*128
  // quotient via reciprocal multiply, exact over this input range
  function automatic div_step_t div_step(logic [3:0] rem_in, logic [6:0] digit,
                                         logic by9);
    div_step_t  r;
    logic [10:0] v;
    logic [25:0] prod;
    logic [10:0] q;
    logic [10:0] back;
    v    = {rem_in, digit};
    prod = 26'(v) * (by9 ? 26'd7282 : 26'd21846);
    q    = 11'(prod[26-1:16]);
    back = q * (by9 ? 11'd9 : 11'd3);
    r.quo = q[6:0];
    r.rem = 4'(v - back);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lattice_boltzmann_d3q19_equilibrium.sv
// ----------------------------------------------------------------------------
// lattice_boltzmann_d3q19_equilibrium: D3Q19 BGK equilibrium generator
// Throughput: one population per cycle while the output is not stalled.
// A new cell is accepted while the sequencer issues the last direction.
// Reset: async active low; clears sequencer and pipeline valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_boltzmann_d3q19_equilibrium (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // cell input
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [15:0]        density_i,
  input  wire logic signed [15:0] velocity_x_i,
  input  wire logic signed [15:0] velocity_y_i,
  input  wire logic signed [15:0] velocity_z_i,
  // populations out
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [4:0]         direction_o,
  output      logic signed [31:0] eq_value_o,
  output      logic               last_o
);

  localparam logic signed [37:0] BrOne   = 38'sd2147483648;
  localparam logic [34:0]        LimRest = 35'd6442450947;   // 3*2^31 + 3
  localparam logic [34:0]        LimNine = 35'd19327352841;  // 9*2^31 + 9
  localparam logic [34:0]        MaxPos  = 35'd2147483647;
  localparam logic [34:0]        MaxNeg  = 35'd2147483648;

  // whole pipeline moves together whenever the output register can advance
  logic adv;
  logic accept;

  // ---------------------------------------------------------------- sequencer
  logic                              busy_q;
  logic [lbm_eq_pkg::DirW-1:0]       dir_q;
  logic [15:0]                       rho_q;
  logic signed [15:0]                vx_q, vy_q, vz_q;

  assign adv        = !out_valid_o || !out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = !(adv && (!busy_q || (dir_q == lbm_eq_pkg::LastDir)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dir_q  <= '0;
    end else if (adv) begin
      if (accept) begin
        busy_q <= 1'b1;
        dir_q  <= '0;
      end else if (busy_q && (dir_q == lbm_eq_pkg::LastDir)) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        dir_q <= dir_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rho_q <= density_i;
      vx_q  <= velocity_x_i;
      vy_q  <= velocity_y_i;
      vz_q  <= velocity_z_i;
    end
  end

  // ---------------------------------------------- stage 1: c.v and squares
  lbm_eq_pkg::dir_info_t     info;
  logic signed [17:0]        s1_s_d;
  logic signed [31:0]        sqx_full, sqy_full, sqz_full;

  logic                      s1_valid_q;
  logic [4:0]                s1_dir_q;
  lbm_eq_pkg::weight_e       s1_wclass_q;
  logic [15:0]               s1_rho_q;
  logic signed [17:0]        s1_s_q;
  logic [30:0]               s1_sqx_q, s1_sqy_q, s1_sqz_q;

  always_comb begin
    info     = lbm_eq_pkg::dir_info(dir_q);
    s1_s_d   = lbm_eq_pkg::vel_term(info.x_en, info.x_neg, vx_q)
             + lbm_eq_pkg::vel_term(info.y_en, info.y_neg, vy_q)
             + lbm_eq_pkg::vel_term(info.z_en, info.z_neg, vz_q);
    sqx_full = vx_q * vx_q;
    sqy_full = vy_q * vy_q;
    sqz_full = vz_q * vz_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dir_q    <= dir_q;
      s1_wclass_q <= info.wclass;
      s1_rho_q    <= rho_q;
      s1_s_q      <= s1_s_d;
      s1_sqx_q    <= sqx_full[30:0];
      s1_sqy_q    <= sqy_full[30:0];
      s1_sqz_q    <= sqz_full[30:0];
    end
  end

  // ------------------------------------------------ stage 2: s^2 and |v|^2
  logic signed [35:0]   s2_full;

  logic                 s2_valid_q;
  logic [4:0]           s2_dir_q;
  lbm_eq_pkg::weight_e  s2_wclass_q;
  logic [15:0]          s2_rho_q;
  logic signed [17:0]   s2_s_q;
  logic [32:0]          s2_sq_q;
  logic [31:0]          s2_vsq_q;

  assign s2_full = s1_s_q * s1_s_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_dir_q    <= s1_dir_q;
      s2_wclass_q <= s1_wclass_q;
      s2_rho_q    <= s1_rho_q;
      s2_s_q      <= s1_s_q;
      s2_sq_q     <= s2_full[32:0];
      s2_vsq_q    <= 32'(s1_sqx_q) + 32'(s1_sqy_q) + 32'(s1_sqz_q);
    end
  end

  // ---------------------------------- stage 3: bracket in units of 2^-31
  logic signed [37:0]   s_ext, sq_ext, vsq_ext, br;

  logic                 s3_valid_q;
  logic [4:0]           s3_dir_q;
  lbm_eq_pkg::weight_e  s3_wclass_q;
  logic [15:0]          s3_rho_q;
  logic [36:0]          s3_mag_q;
  logic                 s3_neg_q;

  always_comb begin
    s_ext   = 38'(s2_s_q);
    sq_ext  = $signed({5'b0, s2_sq_q});
    vsq_ext = $signed({6'b0, s2_vsq_q});
    br      = BrOne + (s_ext <<< 17) + (s_ext <<< 16) + (sq_ext <<< 3) + sq_ext
            - (vsq_ext <<< 1) - vsq_ext;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_dir_q    <= s2_dir_q;
      s3_wclass_q <= s2_wclass_q;
      s3_rho_q    <= s2_rho_q;
      s3_neg_q    <= br[37];
      s3_mag_q    <= br[37] ? 37'(-br) : br[36:0];
    end
  end

  // ----------------------------------------------- stage 4: rho * |bracket|
  logic                 s4_valid_q;
  logic [4:0]           s4_dir_q;
  lbm_eq_pkg::weight_e  s4_wclass_q;
  logic [52:0]          s4_prod_q;
  logic                 s4_neg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_dir_q    <= s3_dir_q;
      s4_wclass_q <= s3_wclass_q;
      s4_neg_q    <= s3_neg_q;
      s4_prod_q   <= 53'(s3_rho_q) * 53'(s3_mag_q);
    end
  end

  // ------------------- stage 5: round, drop the power of two, clamp early
  logic [53:0]  num;
  logic [53:0]  shifted;
  logic [34:0]  lim;
  logic         by9_d;

  logic                 s5_valid_q;
  logic [4:0]           s5_dir_q;
  logic                 s5_neg_q;
  logic                 s5_by9_q;
  logic [34:0]          s5_x_q;

  always_comb begin
    unique case (s4_wclass_q)
      lbm_eq_pkg::WeightAxis: begin
        num     = 54'(s4_prod_q) + 54'(22'd18 << 16);
        shifted = num >> 18;
        by9_d   = 1'b1;
      end
      lbm_eq_pkg::WeightDiag: begin
        num     = 54'(s4_prod_q) + 54'(22'd36 << 16);
        shifted = num >> 19;
        by9_d   = 1'b1;
      end
      default: begin
        num     = 54'(s4_prod_q) + 54'(22'd3 << 16);
        shifted = num >> 17;
        by9_d   = 1'b0;
      end
    endcase
    // anything past the limit saturates either way
    lim = by9_d ? LimNine : LimRest;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_dir_q <= s4_dir_q;
      s5_neg_q <= s4_neg_q;
      s5_by9_q <= by9_d;
      s5_x_q   <= (shifted > 54'(lim)) ? lim : shifted[34:0];
    end
  end

  // ------------------------- stages 6, 7: radix-128 division, two digits each
  lbm_eq_pkg::div_step_t  d6a, d6b, d7a, d7b, d8;

  logic                 s6_valid_q;
  logic [4:0]           s6_dir_q;
  logic                 s6_neg_q;
  logic                 s6_by9_q;
  logic [13:0]          s6_quo_q;
  logic [3:0]           s6_rem_q;
  logic [20:0]          s6_low_q;

  logic                 s7_valid_q;
  logic [4:0]           s7_dir_q;
  logic                 s7_neg_q;
  logic                 s7_by9_q;
  logic [27:0]          s7_quo_q;
  logic [3:0]           s7_rem_q;
  logic [6:0]           s7_low_q;

  always_comb begin
    d6a = lbm_eq_pkg::div_step(4'd0, s5_x_q[34:28], s5_by9_q);
    d6b = lbm_eq_pkg::div_step(d6a.rem, s5_x_q[27:21], s5_by9_q);
    d7a = lbm_eq_pkg::div_step(s6_rem_q, s6_low_q[20:14], s6_by9_q);
    d7b = lbm_eq_pkg::div_step(d7a.rem, s6_low_q[13:7], s6_by9_q);
    d8  = lbm_eq_pkg::div_step(s7_rem_q, s7_low_q, s7_by9_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_dir_q <= s5_dir_q;
      s6_neg_q <= s5_neg_q;
      s6_by9_q <= s5_by9_q;
      s6_quo_q <= {d6a.quo, d6b.quo};
      s6_rem_q <= d6b.rem;
      s6_low_q <= s5_x_q[20:0];

      s7_dir_q <= s6_dir_q;
      s7_neg_q <= s6_neg_q;
      s7_by9_q <= s6_by9_q;
      s7_quo_q <= {s6_quo_q, d7a.quo, d7b.quo};
      s7_rem_q <= d7b.rem;
      s7_low_q <= s6_low_q[6:0];
    end
  end

  // ---------------------------------- output register: last digit, saturate
  logic [34:0]         quo_full;
  logic signed [31:0]  eq_value_d;

  logic [4:0]          dir_out_q;
  logic signed [31:0]  eq_value_q;
  logic                out_valid_q;

  always_comb begin
    quo_full = {s7_quo_q, d8.quo};
    if (s7_neg_q) begin
      eq_value_d = (quo_full > MaxNeg) ? 32'sh8000_0000 : $signed(32'(-quo_full));
    end else begin
      eq_value_d = (quo_full > MaxPos) ? 32'sh7FFF_FFFF : $signed(quo_full[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dir_out_q  <= s7_dir_q;
      eq_value_q <= eq_value_d;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= busy_q;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= s5_valid_q;
      s7_valid_q  <= s6_valid_q;
      out_valid_q <= s7_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign direction_o = dir_out_q;
  assign eq_value_o  = eq_value_q;
  assign last_o      = (dir_out_q == lbm_eq_pkg::LastDir);

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: D3Q19 BGK equilibrium generator testbench
// Drives cells through the input channel (directed table, then random cells)
// with bursty valid, stalls the population channel on shifting patterns, and
// checks every population in order against typed-in values or an exact integer predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RandomCells = 114;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxPrinted  = 40;
  localparam longint      Q428Max     = 64'sd2147483647;
  localparam longint      Q428Min     = -64'sd2147483648;

  typedef struct packed {
    logic [15:0]        density;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic               known;     // values typed in per weight class
    logic signed [31:0] rest_val;
    logic signed [31:0] axis_val;
    logic signed [31:0] diag_val;
  } cell_t;

  typedef struct packed {
    logic [lbm_eq_pkg::DirW-1:0] dir;
    logic signed [31:0]          value;
    logic                        last;
  } population_t;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  // lattice vectors in output order
  localparam int LatticeC [lbm_eq_pkg::NumDirs][3] = '{
    '{ 0,  0,  0},
    '{ 1,  0,  0}, '{-1,  0,  0}, '{ 0,  1,  0}, '{ 0, -1,  0}, '{ 0,  0,  1},
    '{ 0,  0, -1},
    '{ 1,  1,  0}, '{ 1, -1,  0}, '{ 1,  0,  1}, '{ 1,  0, -1},
    '{-1,  1,  0}, '{-1, -1,  0}, '{-1,  0,  1}, '{-1,  0, -1},
    '{ 0,  1,  1}, '{ 0,  1, -1}, '{ 0, -1,  1}, '{ 0, -1, -1}
  };

  // zero density, rest velocity and the density extremes are typed in
  localparam int unsigned NumDirected = 16;
  localparam cell_t DirectedCells [NumDirected] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'sd0, 32'sd0, 32'sd0},
    '{16'h0000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 32'sd0, 32'sd0, 32'sd0},
    '{16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      32'sd89478485, 32'sd14913081, 32'sd7456540},
    '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      32'sd357908480, 32'sd59651413, 32'sd29825707},
    '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      32'sd5461, 32'sd910, 32'sd455},
    '{16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{16'hFFFF, 16'h0000, 16'h7FFF, 16'h0000, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{16'hFFFF, 16'h0000, 16'h8000, 16'h0000, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{16'hFFFF, 16'h0000, 16'h0000, 16'h7FFF, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    // strongly negative rest population
    '{16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 32'sd0, 32'sd0, 32'sd0},
    '{16'h7FFF, 16'h5555, 16'hD556, 16'h0001, 1'b0, 32'sd0, 32'sd0, 32'sd0}
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic [15:0]        density     = '0;
  logic signed [15:0] velocity_x  = '0;
  logic signed [15:0] velocity_y  = '0;
  logic signed [15:0] velocity_z  = '0;
  cell_t              in_cell     = '0;  // travels with the payload
  logic               out_stall   = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [4:0]         direction_o;
  logic signed [31:0] eq_value_o;
  logic               last_o;

  population_t        pending_pops [$];
  int unsigned        n_errors    = 0;
  int unsigned        cycle_cnt   = 0;
  int unsigned        burst_left  = 0;
  stall_mode_e        stall_mode  = StallNone;
  int unsigned        stall_span  = 0;

  lattice_boltzmann_d3q19_equilibrium i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .density_i   (density),
    .velocity_x_i(velocity_x),
    .velocity_y_i(velocity_y),
    .velocity_z_i(velocity_z),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .direction_o (direction_o),
    .eq_value_o  (eq_value_o),
    .last_o      (last_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic lbm_eq_pkg::weight_e dir_weight(int unsigned d);
    int nz;
    nz = (LatticeC[d][0] != 0) + (LatticeC[d][1] != 0) + (LatticeC[d][2] != 0);
    if (nz == 0) begin
      return lbm_eq_pkg::WeightRest;
    end else if (nz == 1) begin
      return lbm_eq_pkg::WeightAxis;
    end
    return lbm_eq_pkg::WeightDiag;
  endfunction

  // exact bracket in units of 2^-31, one rounding to Q4.28, then saturation
  function automatic logic signed [31:0] eq_population(int unsigned d, cell_t c);
    longint          s;
    longint          vsq;
    longint          bracket;
    longint          num;
    longint          den;
    longint          q;
    longint unsigned mag;
    s = LatticeC[d][0] * longint'(c.vx) + LatticeC[d][1] * longint'(c.vy)
      + LatticeC[d][2] * longint'(c.vz);
    vsq = longint'(c.vx) * c.vx + longint'(c.vy) * c.vy + longint'(c.vz) * c.vz;
    bracket = (longint'(1) << 31) + 3 * s * 65536 + 9 * s * s - 3 * vsq;
    num = longint'({48'd0, c.density}) * bracket;
    case (dir_weight(d))
      lbm_eq_pkg::WeightRest: den = 3 * 131072;
      lbm_eq_pkg::WeightAxis: den = 18 * 131072;
      default:                den = 36 * 131072;
    endcase
    mag = (num < 0) ? longint'(-num) : num;
    q = longint'((mag + den / 2) / den);
    if (num < 0) begin
      q = -q;
    end
    if (q > Q428Max) begin
      return 32'h7FFF_FFFF;
    end else if (q < Q428Min) begin
      return 32'h8000_0000;
    end
    return q[31:0];
  endfunction

  function automatic logic signed [15:0] pick_velocity();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      return 16'($signed($urandom_range(0, 4096)) - 2048);
    end else if (sel < 8) begin
      return 16'($urandom());
    end
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    int unsigned sel;
    c = '0;
    sel = $urandom_range(0, 19);
    if (sel < 14) begin
      c.density = 16'($urandom());
    end else if (sel < 17) begin
      c.density = 16'($urandom_range(15000, 18000));
    end else begin
      case ($urandom_range(0, 3))
        0:       c.density = 16'h0000;
        1:       c.density = 16'h0001;
        2:       c.density = 16'h8000;
        default: c.density = 16'hFFFF;
      endcase
    end
    c.vx = pick_velocity();
    c.vy = pick_velocity();
    c.vz = pick_velocity();
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < MaxPrinted) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    n_errors++;
  endtask

  task automatic send_cell(input cell_t c);
    in_valid   <= 1'b1;
    density    <= c.density;
    velocity_x <= c.vx;
    velocity_y <= c.vy;
    velocity_z <= c.vz;
    in_cell    <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      // long gaps let the pipeline drain fully now and then
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 5);
    end
  endtask

  // population channel back-pressure
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_span <= $urandom_range(20, 120);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= ((cycle_cnt % 7) < 3);
    endcase
  end

  // expectations on input transfers, comparison on output transfers
  always @(posedge clk_i) begin
    population_t exp_pop;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        for (int unsigned d = 0; d < lbm_eq_pkg::NumDirs; d++) begin
          exp_pop.dir  = lbm_eq_pkg::DirW'(d);
          exp_pop.last = (lbm_eq_pkg::DirW'(d) == lbm_eq_pkg::LastDir);
          if (in_cell.known) begin
            case (dir_weight(d))
              lbm_eq_pkg::WeightRest: exp_pop.value = in_cell.rest_val;
              lbm_eq_pkg::WeightAxis: exp_pop.value = in_cell.axis_val;
              default:                exp_pop.value = in_cell.diag_val;
            endcase
          end else begin
            exp_pop.value = eq_population(d, in_cell);
          end
          pending_pops.push_back(exp_pop);
        end
      end
      if (out_valid_o && !out_stall) begin
        if (pending_pops.size() == 0) begin
          report_mismatch($sformatf("population dir %0d with nothing pending", direction_o));
        end else begin
          exp_pop = pending_pops.pop_front();
          if (direction_o !== exp_pop.dir) begin
            report_mismatch($sformatf("direction %0d, want %0d", direction_o, exp_pop.dir));
          end
          if (eq_value_o !== exp_pop.value) begin
            report_mismatch($sformatf("dir %0d value %0d, want %0d",
                                      exp_pop.dir, eq_value_o, exp_pop.value));
          end
          if (last_o !== exp_pop.last) begin
            report_mismatch($sformatf("dir %0d last %0b, want %0b",
                                      exp_pop.dir, last_o, exp_pop.last));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cell_t c;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 6);
    for (int unsigned i = 0; i < NumDirected; i++) begin
      send_cell(DirectedCells[i]);
    end
    for (int unsigned i = 0; i < RandomCells; i++) begin
      c = random_cell();
      send_cell(c);
    end
    in_valid <= 1'b0;
    while (pending_pops.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
